>>> rtl/qts_pkg.sv
// qts_pkg: widths, codes, controller states, datapath commands and shared structs
// for the quintic trajectory sampler; no dependencies
package qts_pkg;

  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 12;
  localparam int AXES      = 3;
  localparam int NCOEF     = 6;
  localparam int D_W       = 33;
  localparam int SQ_W      = 66;
  localparam int RAD_W     = 68;
  localparam int DIST_W    = 34;
  localparam int N_W       = 50;
  localparam int HV_W      = 64;
  localparam int DIV_NUM_W = 96;
  localparam int DIV_DEN_W = 64;
  localparam int COEF_W    = 61;
  localparam int ACC_W     = 64;
  localparam int XW        = 66;
  localparam int MA_W      = 33;
  localparam int MB_W      = 34;
  localparam int PROD_W    = 67;
  localparam int S_W       = 32;
  localparam int RAW_W     = 51;

  localparam int MAX_SAMPLES_DEF = 4096;

  localparam logic [CFG_W-1:0] SPEED_RST  = 32'd131072;
  localparam logic [CFG_W-1:0] PERIOD_RST = 32'd2621;
  localparam logic [ACC_W-1:0] COEF_LIM   = 64'h0800_0000_0000_0000;

  typedef enum logic {
    CFG_AVG_SPEED     = 1'b0,
    CFG_SAMPLE_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_PLAN   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SQ, ST_VH, ST_SQRT_GO, ST_SQRT_WAIT,
    ST_RAW_GO, ST_RAW_WAIT, ST_RAW, ST_STEP_GO, ST_STEP_WAIT, ST_STEP,
    ST_WMUL, ST_W_GO, ST_W_WAIT, ST_COEF,
    ST_IDX, ST_SREG, ST_PLOAD, ST_HA, ST_HB, ST_HC, ST_RND, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_SQ, DP_VH, DP_SQRT_GO, DP_RAW_GO, DP_RAW,
    DP_STEP_GO, DP_STEP, DP_WMUL, DP_W_GO, DP_COEF,
    DP_IDX, DP_SREG, DP_PLOAD, DP_HA, DP_HB, DP_HC, DP_RND, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [2:0] k;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic sqrt_done;
    logic div_done;
    logic raw_ge2;
  } stat_t;

  typedef struct packed {
    logic                      operation;
    logic [2:0][POS_W-1:0]     begin_p;
    logic [2:0][POS_W-1:0]     end_p;
    logic [2:0][POS_W-1:0]     vel_p;
    logic [IDX_W-1:0]          sample_index;
  } in_word_t;

endpackage

>>> rtl/quintic_trajectory_sampler_unit.sv
// quintic_trajectory_sampler_unit: top level, joins qts_ctrl and qts_dp
// depends on qts_pkg, qts_ctrl, qts_dp
//
//   channel  handshake             payload
//   in       in_valid / in_ready   operation, begin, end, start velocity, sample index
//   out      out_valid / out_ready pos x/y/z, sample count, index clamped, too long
//   cfg      cfg_valid / cfg_ready cfg_index (0 speed, 1 period), cfg_data
//
// a plan word runs 34 sqrt steps and up to five 96-step divisions
// (no step division for a single-sample path)
// a sample word runs per axis a coefficient load, five horner steps
// and a rounding step
// one word is in work at a time; the next is taken while a result waits at out
// synchronous active-low reset clears control, counts and config; cfg is always ready
module quintic_trajectory_sampler_unit #(
  parameter int MAX_SAMPLES = qts_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [qts_pkg::POS_W-1:0]     in_begin_x,
  input  logic signed [qts_pkg::POS_W-1:0]     in_begin_y,
  input  logic signed [qts_pkg::POS_W-1:0]     in_begin_z,
  input  logic signed [qts_pkg::POS_W-1:0]     in_end_x,
  input  logic signed [qts_pkg::POS_W-1:0]     in_end_y,
  input  logic signed [qts_pkg::POS_W-1:0]     in_end_z,
  input  logic signed [qts_pkg::POS_W-1:0]     in_start_vel_x,
  input  logic signed [qts_pkg::POS_W-1:0]     in_start_vel_y,
  input  logic signed [qts_pkg::POS_W-1:0]     in_start_vel_z,
  input  logic [qts_pkg::IDX_W-1:0]            in_sample_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qts_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [qts_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [qts_pkg::POS_W-1:0]     out_pos_z,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]     out_sample_count,
  output logic                                 out_index_clamped,
  output logic                                 out_too_long,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [qts_pkg::CFG_W-1:0]            cfg_data
);
  import qts_pkg::*;

  cmd_t                  cmd;
  stat_t                 stat;
  in_word_t              in_word;
  logic [2:0][POS_W-1:0] pos;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_word.operation    = in_operation;
    in_word.begin_p      = {in_begin_z, in_begin_y, in_begin_x};
    in_word.end_p        = {in_end_z, in_end_y, in_end_x};
    in_word.vel_p        = {in_start_vel_z, in_start_vel_y, in_start_vel_x};
    in_word.sample_index = in_sample_index;
  end

  qts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qts_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_word      (in_word),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_pos      (pos),
    .out_count    (out_sample_count),
    .out_clamped  (out_index_clamped),
    .out_too_long (out_too_long)
  );

  assign out_pos_x = $signed(pos[0]);
  assign out_pos_y = $signed(pos[1]);
  assign out_pos_z = $signed(pos[2]);
endmodule

>>> rtl/qts_div.sv
// qts_div: restoring unsigned divider, one quotient bit per cycle
// standalone; used by qts_dp
module qts_div #(
  parameter int NUM_W = 96,
  parameter int DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic             rem_nz
);
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] nq_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rs;
  logic             ge;

  assign rs = {rem_r, nq_r[NUM_W-1]};
  assign ge = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      nq_r  <= {nq_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(rs - {1'b0, den_r}) : rs[DEN_W-1:0];
    end
  end

  assign done   = done_r;
  assign quo    = nq_r;
  assign rem_nz = rem_r != '0;
endmodule

>>> rtl/qts_sqrt.sv
// qts_sqrt: digit-by-digit integer square root, one root bit per cycle
// standalone; used by qts_dp
module qts_sqrt #(
  parameter int RAD_W = 68
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RAD_W-1:0]     rad,
  output logic                 done,
  output logic [RAD_W/2-1:0]   root
);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  rs;
  logic [REM_W+1:0]  trial;
  logic              ge;

  assign rs    = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial = (REM_W+2)'({root_r, 2'b01});
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? REM_W'(rs - trial) : rs[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> rtl/qts_dp.sv
// qts_dp: datapath with config registers, shared multiplier, sqrt and divider units,
// coefficient registers and output word; depends on qts_pkg, qts_div, qts_sqrt
module qts_dp #(
  parameter int MAX_SAMPLES = qts_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  qts_pkg::cmd_t                         cmd,
  output qts_pkg::stat_t                        stat,
  input  qts_pkg::in_word_t                     in_word,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [qts_pkg::CFG_W-1:0]             cfg_data,
  output logic [2:0][qts_pkg::POS_W-1:0]        out_pos,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]      out_count,
  output logic                                  out_clamped,
  output logic                                  out_too_long
);
  import qts_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int Q_W   = ACC_W - 15;

  // config and captured word
  logic [CFG_W-1:0]        avg_r, per_r;
  logic                    op_r;
  logic [2:0][POS_W-1:0]   b_r, e_r, v0_r;
  logic [IDX_W-1:0]        idx_r;

  // work registers
  logic [PROD_W-1:0]       prod_r;
  logic [SQ_W-1:0]         sumsq_r;
  logic [HV_W-1:0]         hv_r;
  logic [CNT_W-1:0]        count_r;
  logic                    too_long_r;
  logic [S_W-1:0]          step_r;
  logic                    planned_r;
  logic signed [COEF_W-1:0] coef_r [AXES][NCOEF];
  logic                    clamped_r;
  logic [S_W-1:0]          s_r;
  logic [ACC_W-1:0]        m_r;
  logic signed [ACC_W-1:0] p_r;
  logic [2:0][POS_W-1:0]   pos_r;

  // output word
  logic [2:0][POS_W-1:0]   out_pos_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_clamped_r, out_too_long_r;

  logic signed [D_W-1:0]   d_s   [AXES];
  logic [D_W-1:0]          d_mag [AXES];
  logic [POS_W-1:0]        vmag  [AXES];
  logic [CFG_W-1:0]        v_eff, h_eff;
  logic [DIST_W-1:0]       span_len;
  logic [N_W-1:0]          n_val;
  logic [MA_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [PROD_W-1:0]       prod;
  logic                    sqrt_start, sqrt_done;
  logic                    div_start, div_done, rem_nz;
  logic [DIV_NUM_W-1:0]    div_num, quo;
  logic [DIV_DEN_W-1:0]    div_den;
  logic [RAW_W-1:0]        raw;
  logic [CNT_W-1:0]        last;
  logic                    clamp;
  logic [IDX_W-1:0]        idx_cl;
  logic [ACC_W-1:0]        pmag;
  logic [ACC_W-1:0]        m_sum;
  logic signed [ACC_W-1:0] coef_k;
  logic signed [ACC_W:0]   rnd_sum;
  logic signed [Q_W-1:0]   rnd_q;
  logic [POS_W-1:0]        rnd_pos;
  logic [ACC_W-1:0]        wmag;
  logic signed [XW-1:0]    w_x, dq_x;
  logic signed [COEF_W-1:0] c3, c4, c5;

  function automatic logic signed [COEF_W-1:0] clamp_coef(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] lim;
    lim = $signed(XW'(COEF_LIM));
    if (v > lim) return COEF_W'(lim);
    else if (v < -lim) return COEF_W'(-lim);
    else return COEF_W'(v);
  endfunction

  always_comb begin
    for (int ax = 0; ax < AXES; ax++) begin
      d_s[ax]   = $signed({e_r[ax][POS_W-1], e_r[ax]}) - $signed({b_r[ax][POS_W-1], b_r[ax]});
      d_mag[ax] = d_s[ax][D_W-1] ? D_W'(-d_s[ax]) : D_W'(d_s[ax]);
      vmag[ax]  = v0_r[ax][POS_W-1] ? (~v0_r[ax] + POS_W'(1)) : v0_r[ax];
    end
  end

  // zero registers act as one lsb
  assign v_eff = (avg_r == '0) ? CFG_W'(1) : avg_r;
  assign h_eff = (per_r == '0) ? CFG_W'(1) : per_r;
  assign n_val = {span_len, 16'b0};
  assign pmag  = p_r[ACC_W-1] ? ACC_W'(-p_r) : ACC_W'(p_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_SQ: begin
        mul_a = d_mag[cmd.axis];
        mul_b = MB_W'(d_mag[cmd.axis]);
      end
      DP_VH: begin
        mul_a = MA_W'(v_eff);
        mul_b = MB_W'(h_eff);
      end
      DP_WMUL: begin
        mul_a = MA_W'(vmag[cmd.axis]);
        mul_b = span_len;
      end
      DP_IDX: begin
        mul_a = MA_W'(idx_cl);
        mul_b = MB_W'(step_r);
      end
      DP_HA: begin
        mul_a = MA_W'(pmag[ACC_W-1:32]);
        mul_b = MB_W'(s_r);
      end
      DP_HB: begin
        mul_a = MA_W'(pmag[31:0]);
        mul_b = MB_W'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // divider operand select
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    case (cmd.op)
      DP_RAW_GO: begin
        div_num   = DIV_NUM_W'(n_val);
        div_den   = hv_r;
        div_start = 1'b1;
      end
      DP_STEP_GO: begin
        div_num   = {hv_r, 32'b0};
        div_den   = DIV_DEN_W'(n_val);
        div_start = 1'b1;
      end
      DP_W_GO: begin
        div_num   = DIV_NUM_W'({prod_r, 16'b0});
        div_den   = DIV_DEN_W'(v_eff);
        div_start = 1'b1;
      end
      default: begin
        div_num   = '0;
        div_den   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = cmd.op == DP_SQRT_GO;

  qts_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (RAD_W'(sumsq_r)),
    .done  (sqrt_done),
    .root  (span_len)
  );

  qts_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  // ceiling of distance over speed times period
  assign raw = RAW_W'(quo[RAW_W-2:0]) + RAW_W'(rem_nz);

  // start-velocity term and coefficients of the current axis
  always_comb begin
    wmag = (quo > DIV_NUM_W'(COEF_LIM)) ? COEF_LIM : quo[ACC_W-1:0];
    w_x  = v0_r[cmd.axis][POS_W-1] ? -$signed(XW'(wmag)) : $signed(XW'(wmag));
    dq_x = $signed({{(XW-D_W-16){d_s[cmd.axis][D_W-1]}}, d_s[cmd.axis], 16'b0});
    c3   = clamp_coef(dq_x * 66'sd10 - w_x * 66'sd6);
    c4   = clamp_coef(w_x * 66'sd8 - dq_x * 66'sd15);
    c5   = clamp_coef(dq_x * 66'sd6 - w_x * 66'sd3);
  end

  // index clamp to the last stored sample
  always_comb begin
    last   = (count_r != '0) ? count_r - CNT_W'(1) : '0;
    clamp  = CMP_W'(idx_r) > CMP_W'(last);
    idx_cl = clamp ? IDX_W'(CMP_W'(last)) : idx_r;
  end

  // horner step and rounding
  always_comb begin
    coef_k  = planned_r ? ACC_W'(coef_r[cmd.axis][cmd.k]) : '0;
    m_sum   = m_r + ACC_W'(prod_r[63:32]);
    rnd_sum = $signed({p_r[ACC_W-1], p_r}) + (ACC_W+1)'(32768);
    rnd_q   = Q_W'(rnd_sum >>> 16);
    if (rnd_q > $signed(Q_W'(32'h7fff_ffff))) rnd_pos = 32'h7fff_ffff;
    else if (rnd_q < -$signed(Q_W'(33'h0_8000_0000))) rnd_pos = 32'h8000_0000;
    else rnd_pos = POS_W'(rnd_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r      <= SPEED_RST;
      per_r      <= PERIOD_RST;
      count_r    <= '0;
      step_r     <= '0;
      planned_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_AVG_SPEED) avg_r <= cfg_data;
        else per_r <= cfg_data;
      end
      case (cmd.op)
        DP_RAW: begin
          step_r <= '0;
          if (raw == '0) count_r <= CNT_W'(1);
          else if (raw > RAW_W'(MAX_SAMPLES)) count_r <= CNT_W'(MAX_SAMPLES);
          else count_r <= CNT_W'(raw);
        end
        DP_STEP: step_r <= quo[S_W-1:0];
        DP_COEF: planned_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_r    <= in_word.operation;
        b_r     <= in_word.begin_p;
        e_r     <= in_word.end_p;
        v0_r    <= in_word.vel_p;
        idx_r   <= in_word.sample_index;
        prod_r  <= '0;
        sumsq_r <= '0;
      end
      DP_SQ, DP_VH: begin
        prod_r  <= prod;
        sumsq_r <= sumsq_r + SQ_W'(prod_r);
      end
      DP_SQRT_GO: hv_r <= prod_r[HV_W-1:0];
      DP_RAW: too_long_r <= raw > RAW_W'(MAX_SAMPLES);
      DP_WMUL: prod_r <= prod;
      DP_COEF: begin
        coef_r[cmd.axis][0] <= $signed({{(COEF_W-POS_W-16){b_r[cmd.axis][POS_W-1]}},
                                        b_r[cmd.axis], 16'b0});
        coef_r[cmd.axis][1] <= COEF_W'(w_x);
        coef_r[cmd.axis][2] <= '0;
        coef_r[cmd.axis][3] <= c3;
        coef_r[cmd.axis][4] <= c4;
        coef_r[cmd.axis][5] <= c5;
      end
      DP_IDX: begin
        prod_r    <= prod;
        clamped_r <= clamp;
      end
      DP_SREG: s_r <= prod_r[S_W-1:0];
      DP_PLOAD: p_r <= coef_k;
      DP_HA: prod_r <= prod;
      DP_HB: begin
        m_r    <= prod_r[ACC_W-1:0];
        prod_r <= prod;
      end
      DP_HC: p_r <= coef_k + (p_r[ACC_W-1] ? -$signed(m_sum) : $signed(m_sum));
      DP_RND: pos_r[cmd.axis] <= rnd_pos;
      DP_OUT: begin
        out_count_r <= count_r;
        if (op_r == OP_SAMPLE) begin
          out_pos_r      <= pos_r;
          out_clamped_r  <= clamped_r;
          out_too_long_r <= 1'b0;
        end else begin
          out_pos_r      <= '0;
          out_clamped_r  <= 1'b0;
          out_too_long_r <= too_long_r;
        end
      end
      default: ;
    endcase
  end

  assign stat.is_sample = op_r == OP_SAMPLE;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.raw_ge2   = raw >= RAW_W'(2);

  assign out_pos      = out_pos_r;
  assign out_count    = out_count_r;
  assign out_clamped  = out_clamped_r;
  assign out_too_long = out_too_long_r;
endmodule

>>> rtl/qts_ctrl.sv
// qts_ctrl: sequencer for plan and sample operations, owns the handshakes
// depends on qts_pkg
module qts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  qts_pkg::stat_t  stat,
  output qts_pkg::cmd_t   cmd
);
  import qts_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);
  localparam logic [2:0] TOP_K     = 3'(NCOEF - 2);
  localparam logic [2:0] LEAD_K    = 3'(NCOEF - 1);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        axis_nxt  = '0;
        state_nxt = stat.is_sample ? ST_IDX : ST_SQ;
      end
      ST_SQ: begin
        axis_nxt = axis_r + 2'd1;
        if (axis_r == LAST_AXIS) state_nxt = ST_VH;
      end
      ST_VH:        state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (stat.sqrt_done) state_nxt = ST_RAW_GO;
      ST_RAW_GO:    state_nxt = ST_RAW_WAIT;
      ST_RAW_WAIT:  if (stat.div_done) state_nxt = ST_RAW;
      ST_RAW: begin
        axis_nxt  = '0;
        state_nxt = stat.raw_ge2 ? ST_STEP_GO : ST_WMUL;
      end
      ST_STEP_GO:   state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT: if (stat.div_done) state_nxt = ST_STEP;
      ST_STEP:      state_nxt = ST_WMUL;
      ST_WMUL:      state_nxt = ST_W_GO;
      ST_W_GO:      state_nxt = ST_W_WAIT;
      ST_W_WAIT:    if (stat.div_done) state_nxt = ST_COEF;
      ST_COEF: begin
        if (axis_r == LAST_AXIS) begin
          state_nxt = ST_FIN;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_WMUL;
        end
      end
      ST_IDX:       state_nxt = ST_SREG;
      ST_SREG:      state_nxt = ST_PLOAD;
      ST_PLOAD: begin
        k_nxt     = TOP_K;
        state_nxt = ST_HA;
      end
      ST_HA:        state_nxt = ST_HB;
      ST_HB:        state_nxt = ST_HC;
      ST_HC: begin
        if (k_r == '0) begin
          state_nxt = ST_RND;
        end else begin
          k_nxt     = k_r - 3'd1;
          state_nxt = ST_HA;
        end
      end
      ST_RND: begin
        if (axis_r == LAST_AXIS) begin
          state_nxt = ST_FIN;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_PLOAD;
        end
      end
      ST_FIN:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.axis = axis_r;
    cmd.k    = k_r;
    cmd.op   = DP_NOP;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? DP_LOAD : DP_NOP;
      end
      ST_SQ:      cmd.op = DP_SQ;
      ST_VH:      cmd.op = DP_VH;
      ST_SQRT_GO: cmd.op = DP_SQRT_GO;
      ST_RAW_GO:  cmd.op = DP_RAW_GO;
      ST_RAW:     cmd.op = DP_RAW;
      ST_STEP_GO: cmd.op = DP_STEP_GO;
      ST_STEP:    cmd.op = DP_STEP;
      ST_WMUL:    cmd.op = DP_WMUL;
      ST_W_GO:    cmd.op = DP_W_GO;
      ST_COEF:    cmd.op = DP_COEF;
      ST_IDX:     cmd.op = DP_IDX;
      ST_SREG:    cmd.op = DP_SREG;
      // horner starts from the highest-order coefficient
      ST_PLOAD: begin
        cmd.op = DP_PLOAD;
        cmd.k  = LEAD_K;
      end
      ST_HA:      cmd.op = DP_HA;
      ST_HB:      cmd.op = DP_HB;
      ST_HC:      cmd.op = DP_HC;
      ST_RND:     cmd.op = DP_RND;
      ST_FIN:     cmd.op = out_free ? DP_OUT : DP_NOP;
      default:    cmd.op = DP_NOP;
    endcase
  end

  // result word stays until taken; a new one loads only when the slot frees
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.op == DP_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
